// ===== hw/rtl/b64sc_pkg.sv =====
// Package for the Base64 stream codec: job type, character constants and
// the alphabet mapping functions. No dependencies.
package b64sc_pkg;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One completed group handed from the front to the back.
    typedef struct packed {
        logic [23:0] bits;    // left-aligned group
        logic        mode;    // encode or decode
        logic [2:0]  cnt;     // results to emit, 1..4
        logic [2:0]  nchars;  // encode: characters before padding
        logic        last;    // group closes the message
    } job_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
            return w + 8'd65;
        else if (v < 6'd52)
            return w + 8'd71;
        else if (v < 6'd62)
            return w - 8'd4;
        else if (v == 6'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

    function automatic logic [5:0] dec_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A)
            d = c - 8'h41;
        else if (c >= 8'h61 && c <= 8'h7A)
            d = c - 8'h47;
        else if (c >= 8'h30 && c <= 8'h39)
            d = c + 8'd4;
        else if (c == 8'h2B)
            d = 8'd62;
        else if (c == 8'h2F)
            d = 8'd63;
        return d[5:0];
    endfunction

endpackage

// ===== hw/rtl/b64sc_ifs.sv =====
// Channel interfaces of the Base64 stream codec: input beats, result beats
// and the mode write channel. No dependencies.
interface b64sc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64sc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface b64sc_cfg_if;
    logic valid;
    logic ready;
    logic mode;

    modport source (output valid, output mode, input ready);
    modport sink   (input valid, input mode, output ready);
endinterface

// ===== hw/rtl/b64sc_front.sv =====
// Front end: accepts input beats and mode writes, gathers groups and pushes
// one job per completed group with results. Needs b64sc_pkg, b64sc_ifs.
module b64sc_front (
    input  logic                clk,
    input  logic                rst_n,
    b64sc_in_if.sink            feed,
    b64sc_cfg_if.sink           cfg,
    output logic                push_valid,
    input  logic                push_ready,
    output b64sc_pkg::job_t     push_data
);
    import b64sc_pkg::*;

    logic        mode_reg,  mode_next;
    logic [23:0] bits_reg,  bits_next;
    logic [1:0]  count_reg, count_next;
    logic [1:0]  pad_reg,   pad_next;

    logic        fire;
    logic [2:0]  n;
    logic        done;
    logic [23:0] gathered;
    logic [23:0] aligned;
    logic [1:0]  pad_upd;
    logic [2:0]  pad_lim;
    logic [2:0]  cnt;
    logic [5:0]  sextet;

    assign feed.ready = push_ready;
    assign cfg.ready  = 1'b1;
    assign fire       = feed.valid && push_ready;
    assign n          = {1'b0, count_reg} + 3'd1;
    assign sextet     = dec_value(feed.in_byte);

    always_comb
    begin
        pad_upd  = pad_reg;
        aligned  = 24'd0;
        cnt      = 3'd0;
        if (mode_reg == MODE_ENCODE)
        begin
            gathered = {bits_reg[15:0], feed.in_byte};
            done     = (n == 3'd3) || feed.in_last;
            unique case (n)
                3'd1:    aligned = {gathered[7:0], 16'd0};
                3'd2:    aligned = {gathered[15:0], 8'd0};
                default: aligned = gathered;
            endcase
            cnt = 3'd4;
        end
        else
        begin
            gathered = {bits_reg[17:0], sextet};
            done     = (n == 3'd4) || feed.in_last;
            if (feed.in_byte == PAD_CHAR)
                pad_upd = (pad_reg == 2'd3) ? 2'd3 : pad_reg + 2'd1;
            else
                pad_upd = 2'd0;
            unique case (n)
                3'd1:    aligned = {gathered[5:0], 18'd0};
                3'd2:    aligned = {gathered[11:0], 12'd0};
                3'd3:    aligned = {gathered[17:0], 6'd0};
                default: aligned = gathered;
            endcase
        end
        pad_lim = {1'b0, pad_upd} + 3'd1;
        if (mode_reg == MODE_DECODE)
            cnt = (n > pad_lim) ? (n - pad_lim) : 3'd0;
    end

    always_comb
    begin
        push_data.bits   = aligned;
        push_data.mode   = mode_reg;
        push_data.cnt    = cnt;
        push_data.nchars = n + 3'd1;
        push_data.last   = feed.in_last;
        push_valid       = feed.valid && done && (cnt != 3'd0);
    end

    always_comb
    begin
        mode_next  = mode_reg;
        bits_next  = bits_reg;
        count_next = count_reg;
        pad_next   = pad_reg;
        if (cfg.valid)
        begin
            mode_next  = cfg.mode;
            bits_next  = 24'd0;
            count_next = 2'd0;
            pad_next   = 2'd0;
        end
        else if (fire)
        begin
            if (done)
            begin
                bits_next  = 24'd0;
                count_next = 2'd0;
                pad_next   = 2'd0;
            end
            else
            begin
                bits_next  = gathered;
                count_next = n[1:0];
                pad_next   = pad_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ENCODE;
            bits_reg  <= 24'd0;
            count_reg <= 2'd0;
            pad_reg   <= 2'd0;
        end
        else
        begin
            mode_reg  <= mode_next;
            bits_reg  <= bits_next;
            count_reg <= count_next;
            pad_reg   <= pad_next;
        end
    end

endmodule

// ===== hw/rtl/b64sc_queue.sv =====
// Short job queue between front and back end.
// Depends on b64sc_pkg.
module b64sc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  b64sc_pkg::job_t     push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output b64sc_pkg::job_t     pop_data
);
    import b64sc_pkg::*;

    job_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   fill_reg,   fill_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (fill_reg != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== hw/rtl/b64sc_back.sv =====
// Back end: walks the head job into the output register, one result per
// cycle while that register is free. Depends on b64sc_pkg and b64sc_ifs.
module b64sc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  b64sc_pkg::job_t     pop_data,
    b64sc_out_if.source         result
);
    import b64sc_pkg::*;

    logic [1:0] idx_reg,   idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg,  byte_next;
    logic       last_reg,  last_next;

    logic       slot_free;
    logic       emit;
    logic       final_one;
    logic [5:0] sextet;
    logic [7:0] octet;

    assign slot_free = !valid_reg || result.ready;
    assign emit      = pop_valid && slot_free;
    assign final_one = ({1'b0, idx_reg} == pop_data.cnt - 3'd1);
    assign pop_ready = emit && final_one;

    assign result.valid    = valid_reg;
    assign result.out_byte = byte_reg;
    assign result.out_last = last_reg;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sextet = pop_data.bits[23:18];
            2'd1:    sextet = pop_data.bits[17:12];
            2'd2:    sextet = pop_data.bits[11:6];
            default: sextet = pop_data.bits[5:0];
        endcase
        unique case (idx_reg)
            2'd0:    octet = pop_data.bits[23:16];
            2'd1:    octet = pop_data.bits[15:8];
            2'd2:    octet = pop_data.bits[7:0];
            default: octet = 8'd0;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            last_next  = pop_data.last && final_one;
            if (pop_data.mode == MODE_DECODE)
                byte_next = octet;
            else if ({1'b0, idx_reg} < pop_data.nchars)
                byte_next = enc_char(sextet);
            else
                byte_next = PAD_CHAR;
            idx_next = final_one ? 2'd0 : idx_reg + 2'd1;
        end
        else if (result.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

endmodule

// ===== hw/rtl/base64_stream_codec.sv =====
// Top level of the Base64 stream codec: front end, job queue, back end.
// Depends on b64sc_pkg, b64sc_ifs, b64sc_front, b64sc_queue, b64sc_back.
//
//   channel  role    beat
//   -------  ------  ------------------------------------------
//   cfg      sink    mode (0 encode, 1 decode), clears the group
//   feed     sink    in_byte, in_last
//   result   source  out_byte, out_last
//
// Takes one input beat per cycle while the two-entry job queue has room.
// The back end sends one result per cycle unless stalled, so encoding runs
// at four results per three input beats; a job is queued, its results
// registered. Reset is asynchronous, active low; no clearing pass. A stalled
// result holds the output register; the queue absorbs the front.
module base64_stream_codec (
    input  logic        clk,
    input  logic        rst_n,
    b64sc_cfg_if.sink   cfg,
    b64sc_in_if.sink    feed,
    b64sc_out_if.source result
);
    import b64sc_pkg::*;

    logic push_valid;
    logic push_ready;
    job_t push_data;
    logic pop_valid;
    logic pop_ready;
    job_t pop_data;

    b64sc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed       (feed),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    b64sc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    b64sc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule
